// File: src/wbar_pkg.sv
// ----------------------------------------------------------------------------
// wbar_pkg: shared types and constants for the white-box affine/add cipher
// Field widths of the item and result words, item mode codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package wbar_pkg;

	// Field widths of one item word and one result word
	localparam int MODE_W  = 2;
	localparam int LAYER_W = 6;
	localparam int ROW_W   = 7;
	localparam int WORD_W  = 64;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_LOAD_ROW   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_CONST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ENCRYPT    = 2'd2;

	// Round sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_MIX,
		ST_DONE
	} wbar_state_t;

endpackage

// File: src/wbar_if.sv
// ----------------------------------------------------------------------------
// wbar_if: item and result channels of the white-box affine/add cipher
// Valid/ready channels; a word moves at a rising edge with valid and ready
// both high.
// ----------------------------------------------------------------------------
interface wbar_in_if;
	import wbar_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [LAYER_W-1:0] layer_index;
	logic [ROW_W-1:0]   row_index;
	logic [WORD_W-1:0]  data_x;
	logic [WORD_W-1:0]  data_y;

	modport source (output valid, mode, layer_index, row_index, data_x, data_y,
		input ready);
	modport sink (input valid, mode, layer_index, row_index, data_x, data_y,
		output ready);
endinterface

interface wbar_out_if;
	import wbar_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] cipher_x;
	logic [WORD_W-1:0] cipher_y;

	modport source (output valid, cipher_x, cipher_y, input ready);
	modport sink (input valid, cipher_x, cipher_y, output ready);
endinterface

// File: src/white_box_affine_add_round_cipher_core.sv
// ----------------------------------------------------------------------------
// white_box_affine_add_round_cipher_core: white-box affine/add round cipher
// Table-driven block cipher: ROUND_COUNT+1 affine layers (binary matrix and
// constant), with a modular add of the high half into the low half after
// every layer but the last.
// ----------------------------------------------------------------------------
// Usage:
//   item   : load words (mode 0 matrix row, mode 1 layer constant) and
//            encrypt words (mode 2, plaintext in data_x / data_y).
//   result : one word (cipher_x, cipher_y) per encrypt word; loads give none.
//   Load words are written straight into the tables.
//   An encrypt word runs each layer through the RUN, WAIT and MIX states,
//   and the result is loaded into the output register in DONE. The pace is
//   set by the single matrix memory port: one 2*HALF_WIDTH bit row is read
//   and folded into one state bit per cycle in RUN; WAIT drains the read
//   and MIX mixes in the constant and the add for each layer.
//   item.ready is low while an encryption runs; loads and new items are
//   taken while a finished result still waits in the output register.
//   If the receiver stalls, the result holds and the next encryption waits
//   at its end until the output register frees.
//   Reset clears the sequencer and the output valid; the tables are not
//   cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module white_box_affine_add_round_cipher_core #(
	parameter int ROUND_COUNT = 34,
	parameter int HALF_WIDTH  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	wbar_in_if.sink    item,
	wbar_out_if.source result
);
	import wbar_pkg::*;

	localparam int LAYERS    = ROUND_COUNT + 1;
	localparam int LW        = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int ROWS      = 2 * HALF_WIDTH;
	localparam int RW        = $clog2(ROWS);
	localparam int MAT_DEPTH = LAYERS * (1 << RW);

	// Sequencer
	wbar_state_t state_q, state_next;
	logic        item_ready;
	logic        out_load;
	logic        row_last;
	logic        layer_last;

	// Counters and read pipeline
	logic [RW-1:0] row_q;
	logic [LW-1:0] layer_q;
	logic          rd_vld_s1;
	logic [RW-1:0] row_s1;
	logic [ROWS-1:0] mat_rd_s1;
	logic [ROWS-1:0] cst_q;

	// Cipher state and next-layer accumulator, {y, x}
	logic [ROWS-1:0] val_q;
	logic [ROWS-1:0] acc_q;
	logic [HALF_WIDTH-1:0] mix_x;
	logic [HALF_WIDTH-1:0] mix_y;

	// Output register
	logic                  out_valid_q;
	logic [HALF_WIDTH-1:0] out_x_q;
	logic [HALF_WIDTH-1:0] out_y_q;

	// Tables
	logic [ROWS-1:0] mat_mem [MAT_DEPTH];
	logic [ROWS-1:0] cst_mem [LAYERS];

	// Decode the item word
	logic             acc_item;
	logic             enc_acc;
	logic             layer_ok;
	logic             row_ok;
	logic [6:0]       layer_ext;
	logic [LW-1:0]    ld_layer;
	logic [RW-1:0]    ld_row;

	assign acc_item  = item.valid && item_ready;
	assign enc_acc   = acc_item && (item.mode == MODE_ENCRYPT);
	assign layer_ext = {1'b0, item.layer_index};
	assign layer_ok  = (layer_ext <= 7'(ROUND_COUNT));
	assign row_ok    = ({1'b0, item.row_index} < 8'(ROWS));
	assign ld_layer  = layer_ext[LW-1:0];
	assign ld_row    = item.row_index[RW-1:0];

	assign row_last   = (row_q == RW'(ROWS - 1));
	assign layer_last = (layer_q == LW'(ROUND_COUNT));

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (enc_acc) state_next = ST_RUN;
			end
			ST_RUN: begin
				if (row_last) state_next = ST_WAIT;
			end
			ST_WAIT: begin
				state_next = ST_MIX;
			end
			ST_MIX: begin
				state_next = layer_last ? ST_DONE : ST_RUN;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
			end
			ST_DONE: begin
				out_load = !out_valid_q || result.ready;
			end
			default: begin
				item_ready = 1'b0;
				out_load   = 1'b0;
			end
		endcase
	end

	// Advance state, counters and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			layer_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_next;
			rd_vld_s1 <= (state_q == ST_RUN);
			if (enc_acc) begin
				row_q   <= '0;
				layer_q <= '0;
			end else if (state_q == ST_RUN) begin
				row_q <= row_q + 1'b1;
			end else if (state_q == ST_MIX) begin
				row_q <= '0;
				if (!layer_last) layer_q <= layer_q + 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// Write the tables on load words
	always_ff @(posedge clk) begin
		if (acc_item && item.mode == MODE_LOAD_ROW && layer_ok && row_ok) begin
			mat_mem[{ld_layer, ld_row}] <= {item.data_y[HALF_WIDTH-1:0],
				item.data_x[HALF_WIDTH-1:0]};
		end
		if (acc_item && item.mode == MODE_LOAD_CONST && layer_ok) begin
			cst_mem[ld_layer] <= {item.data_y[HALF_WIDTH-1:0],
				item.data_x[HALF_WIDTH-1:0]};
		end
	end

	// Read one matrix row and the layer constant per cycle
	always_ff @(posedge clk) begin
		mat_rd_s1 <= mat_mem[{layer_q, row_q}];
		row_s1    <= row_q;
		cst_q     <= cst_mem[layer_q];
	end

	// Layer constant (XOR) for the end-of-layer mix; the modular add follows in the state update
	assign mix_x = acc_q[HALF_WIDTH-1:0] ^ cst_q[HALF_WIDTH-1:0];
	assign mix_y = acc_q[ROWS-1:HALF_WIDTH] ^ cst_q[ROWS-1:HALF_WIDTH];

	// Fold each row into one state bit; update the state per layer
	always_ff @(posedge clk) begin
		if (rd_vld_s1) acc_q[row_s1] <= ^(mat_rd_s1 & val_q);
		if (enc_acc) begin
			val_q <= {item.data_y[HALF_WIDTH-1:0], item.data_x[HALF_WIDTH-1:0]};
		end else if (state_q == ST_MIX) begin
			val_q <= {mix_y, layer_last ? mix_x : mix_x + mix_y};
		end
		if (out_load) begin
			out_x_q <= val_q[HALF_WIDTH-1:0];
			out_y_q <= val_q[ROWS-1:HALF_WIDTH];
		end
	end

	assign item.ready      = item_ready;
	assign result.valid    = out_valid_q;
	assign result.cipher_x = WORD_W'(out_x_q);
	assign result.cipher_y = WORD_W'(out_y_q);

endmodule

// File: src/wbar_checker.sv
// ----------------------------------------------------------------------------
// wbar_checker: port-level checks for the white-box affine/add cipher core
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module wbar_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic [wbar_pkg::MODE_W-1:0] item_mode,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [wbar_pkg::WORD_W-1:0] cipher_x,
	input logic [wbar_pkg::WORD_W-1:0] cipher_y
);
	import wbar_pkg::*;

	// Hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(cipher_x) && $stable(cipher_y))
		else $error("stalled result word changed");

	// Drop ready once an encrypt word is taken
	a_busy_after_encrypt: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_mode == MODE_ENCRYPT |=> !item_ready)
		else $error("ready stayed high after an encrypt word");

	// Keep ready after any other word
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_mode != MODE_ENCRYPT |=> item_ready)
		else $error("ready dropped after a load word");

	// A new result only closes an encryption that held off the item channel
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result appeared without a running encryption");

endmodule

bind white_box_affine_add_round_cipher_core wbar_checker u_wbar_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_mode    (item.mode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.cipher_x     (result.cipher_x),
	.cipher_y     (result.cipher_y)
);
